>>> hdl/bbl_pkg.sv
// package for the byte budget lru cache directory
// shared types, operation codes and default sizes; no dependencies
`timescale 1ns / 1ps

package bbl_pkg;

    // default sizes handed to the top level parameters
    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 32;

    // fixed field widths of the stream and register interfaces
    localparam int FUNC_W   = 2;
    localparam int TAG_W    = 32;
    localparam int SIZE_W   = 32;
    localparam int TOTAL_W  = 36;
    localparam int BUDGET_W = 32;
    localparam int IN_W     = 72;
    localparam int OUT_W    = 104;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // register word index of the byte budget
    localparam logic REG_BUDGET = 1'b0;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_TRIM   = 2'd2
    } t_func;

    // controller states, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic shift_en;    // cells up to the shift boundary take their left neighbor
        logic evict_tail;  // the least-recent valid cell drops its entry
    } t_cell_ctl;

endpackage

>>> hdl/byte_budget_lru_cache_directory_unit.sv
// top level of the byte budget lru cache directory
// depends on bbl_pkg and the bbl_cell row
`timescale 1ns / 1ps

// The directory keeps up to ENTRIES assets in a row of cells ordered by recency,
// most recent in cell 0, together with a 36-bit running byte total. Every
// eviction (a full-table insert, or each entry dropped by a trim while the total
// exceeds a nonzero budget) gives one result ahead of the final one. The row
// retires one tail entry per cycle while the output is not stalled. A new item
// is taken only after the final result of the previous one has been loaded for
// output. budget_bytes is written over the APB port at address 0 and is applied
// only by a trim.
module byte_budget_lru_cache_directory_unit #(
    parameter int ENTRIES  = bbl_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = bbl_pkg::KEY_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream, tdata: func[1:0], key_tag[33:2], size_bytes[65:34], zero pad
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [bbl_pkg::IN_W-1:0]    i_s_axis_tdata,
    // result stream, tdata: hit[0], evicted_valid[1], evicted_key[33:2],
    // evicted_size[65:34], total_bytes[101:66], zero pad; tlast: last
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [bbl_pkg::OUT_W-1:0]   o_m_axis_tdata,
    output logic                        o_m_axis_tlast,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bbl_pkg::APB_AW-1:0]  paddr,
    input  logic [bbl_pkg::APB_DW-1:0]  pwdata,
    output logic [bbl_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import bbl_pkg::*;

    localparam int KW = (KEY_BITS < TAG_W) ? KEY_BITS : TAG_W;

    // controller and latched item
    t_state              r_state, n_state;
    logic [FUNC_W-1:0]   r_func;
    logic [KW-1:0]       r_key;
    logic [SIZE_W-1:0]   r_size;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic [BUDGET_W-1:0] r_budget;

    // output register
    logic                r_out_valid;
    logic                r_out_hit, n_out_hit;
    logic                r_out_evv, n_out_evv;
    logic [TAG_W-1:0]    r_out_key, n_out_key;
    logic [SIZE_W-1:0]   r_out_size, n_out_size;
    logic [TOTAL_W-1:0]  r_out_total;
    logic                r_out_last, n_out_last;
    logic                w_load;
    logic                w_can_load;
    logic                w_in_xfer;

    // cell row signals
    t_cell_ctl           w_ctl;
    logic [ENTRIES:0]    w_seen;
    logic [ENTRIES-1:0]  w_match;
    logic [ENTRIES-1:0]  w_tail;
    logic [ENTRIES-1:0]  w_valid;
    logic [KW-1:0]       w_key  [ENTRIES];
    logic [SIZE_W-1:0]   w_size [ENTRIES];
    logic [KW-1:0]       w_front_key;
    logic [SIZE_W-1:0]   w_front_size;
    logic                w_seed;

    // selected entries
    logic                w_any_match;
    logic [KW-1:0]       w_m_key;
    logic [SIZE_W-1:0]   w_m_size;
    logic [KW-1:0]       w_t_key;
    logic [SIZE_W-1:0]   w_t_size;
    logic                w_full;
    logic                w_over;

    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_can_load      = !r_out_valid || i_m_axis_tready;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BUDGET) ? r_budget : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= '0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BUDGET)) begin
            r_budget <= pwdata;
        end
    end

    // row of cells, cell 0 most recent
    assign w_seen[ENTRIES] = w_seed;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic              w_lv;
        logic [KW-1:0]     w_lk;
        logic [SIZE_W-1:0] w_ls;
        logic              w_rv;
        if (g == 0) begin : g_front
            assign w_lv = 1'b1;
            assign w_lk = w_front_key;
            assign w_ls = w_front_size;
        end else begin : g_mid
            assign w_lv = w_valid[g-1];
            assign w_lk = w_key[g-1];
            assign w_ls = w_size[g-1];
        end
        if (g == ENTRIES - 1) begin : g_end
            assign w_rv = 1'b0;
        end else begin : g_inner
            assign w_rv = w_valid[g+1];
        end
        bbl_cell #(
            .KW (KW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_cmp_key     (r_key),
            .i_left_valid  (w_lv),
            .i_left_key    (w_lk),
            .i_left_size   (w_ls),
            .i_right_valid (w_rv),
            .i_seen        (w_seen[g+1]),
            .o_seen        (w_seen[g]),
            .o_match       (w_match[g]),
            .o_tail        (w_tail[g]),
            .o_valid       (w_valid[g]),
            .o_key         (w_key[g]),
            .o_size        (w_size[g])
        );
    end

    // pick the matching entry and the least-recent entry (each at most one)
    always_comb begin
        w_m_key  = '0;
        w_m_size = '0;
        w_t_key  = '0;
        w_t_size = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_m_key  = w_m_key  | (w_match[i] ? w_key[i]  : '0);
            w_m_size = w_m_size | (w_match[i] ? w_size[i] : '0);
            w_t_key  = w_t_key  | (w_tail[i]  ? w_key[i]  : '0);
            w_t_size = w_t_size | (w_tail[i]  ? w_size[i] : '0);
        end
    end

    assign w_any_match = |w_match;
    assign w_full      = w_valid[ENTRIES-1];
    assign w_over      = (r_budget != '0) && (r_total > {4'b0, r_budget}) && w_valid[0];

    // step of the current item
    always_comb begin
        n_state      = r_state;
        n_total      = r_total;
        w_ctl        = '0;
        w_seed       = 1'b0;
        w_front_key  = r_key;
        w_front_size = r_size;
        w_load       = 1'b0;
        n_out_hit    = 1'b0;
        n_out_evv    = 1'b0;
        n_out_key    = '0;
        n_out_size   = '0;
        n_out_last   = 1'b1;
        if (r_state == S_RUN && w_can_load) begin
            w_load  = 1'b1;
            n_state = S_IDLE;
            case (r_func)
                FUNC_LOOKUP: begin
                    w_ctl.shift_en = w_any_match;
                    w_front_key    = w_m_key;
                    w_front_size   = w_m_size;
                    n_out_hit      = w_any_match;
                end
                FUNC_INSERT: begin
                    if (w_any_match) begin
                        // replace the old entry silently, moving the tag to the front
                        w_ctl.shift_en = 1'b1;
                        n_total = r_total - {4'b0, w_m_size} + {4'b0, r_size};
                    end else if (w_full) begin
                        // make room first, report the evicted entry
                        w_ctl.evict_tail = 1'b1;
                        n_total    = r_total - {4'b0, w_t_size};
                        n_out_evv  = 1'b1;
                        n_out_key  = TAG_W'(w_t_key);
                        n_out_size = w_t_size;
                        n_out_last = 1'b0;
                        n_state    = S_RUN;
                    end else begin
                        w_ctl.shift_en = 1'b1;
                        w_seed         = 1'b1;
                        n_total        = r_total + {4'b0, r_size};
                    end
                end
                FUNC_TRIM: begin
                    if (w_over) begin
                        w_ctl.evict_tail = 1'b1;
                        n_total    = r_total - {4'b0, w_t_size};
                        n_out_evv  = 1'b1;
                        n_out_key  = TAG_W'(w_t_key);
                        n_out_size = w_t_size;
                        n_out_last = 1'b0;
                        n_state    = S_RUN;
                    end
                end
                default: begin
                end
            endcase
        end else if (r_state == S_IDLE && w_in_xfer) begin
            n_state = S_RUN;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // latched item
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_func <= i_s_axis_tdata[1:0];
            r_key  <= i_s_axis_tdata[2 +: KW];
            r_size <= i_s_axis_tdata[65:34];
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_hit   <= n_out_hit;
            r_out_evv   <= n_out_evv;
            r_out_key   <= n_out_key;
            r_out_size  <= n_out_size;
            r_out_total <= n_total;
            r_out_last  <= n_out_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {2'b0, r_out_total, r_out_size, r_out_key, r_out_evv, r_out_hit};

    // tags in the row are unique
    a_unique_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("more than one cell matches the tag");

    // valid cells form a prefix of the row
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (((w_valid >> 1) & ~w_valid) == '0))
        else $error("gap in the valid cells");

    // an eviction result is never the final result
    a_evict_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_evv && r_out_last))
        else $error("final result reports an eviction");

    // no new item is taken while one is in progress
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> !o_s_axis_tready)
        else $error("input ready while an item is in progress");

endmodule

>>> hdl/bbl_cell.sv
// one directory cell: holds the entry at one recency place
// uses bbl_pkg for the control struct; instantiated as a row by the top level
`timescale 1ns / 1ps

module bbl_cell #(
    parameter int KW = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bbl_pkg::t_cell_ctl        i_ctl,
    input  logic [KW-1:0]             i_cmp_key,
    input  logic                      i_left_valid,
    input  logic [KW-1:0]             i_left_key,
    input  logic [bbl_pkg::SIZE_W-1:0] i_left_size,
    input  logic                      i_right_valid,
    input  logic                      i_seen,
    output logic                      o_seen,
    output logic                      o_match,
    output logic                      o_tail,
    output logic                      o_valid,
    output logic [KW-1:0]             o_key,
    output logic [bbl_pkg::SIZE_W-1:0] o_size
);
    import bbl_pkg::*;

    logic              r_valid;
    logic [KW-1:0]     r_key;
    logic [SIZE_W-1:0] r_size;
    logic              w_shift;

    // tag compare and the shift boundary chain, running from the tail end
    assign o_match = r_valid && (r_key == i_cmp_key);
    assign o_seen  = i_seen | o_match;
    assign w_shift = i_ctl.shift_en & o_seen;
    assign o_tail  = r_valid & ~i_right_valid;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_shift) begin
            r_valid <= i_left_valid;
        end else if (i_ctl.evict_tail && o_tail) begin
            r_valid <= 1'b0;
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_key  <= i_left_key;
            r_size <= i_left_size;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_size  = r_size;

endmodule

>>> test/tb_top.sv
// self-checking testbench for byte_budget_lru_cache_directory_unit
// drives request transfers and budget writes, predicts every result in a directory mirror
// depends on bbl_pkg and the rtl top level only
`timescale 1ns / 1ps

module tb_top;

    import bbl_pkg::*;

    localparam int N_SLOTS     = ENTRIES_DEF;
    localparam int SLOT_W      = $clog2(N_SLOTS);
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 38;
    localparam int KEY_POOL    = 24;

    // func code with no operation behind it
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // register addresses: the budget, and one word past the register list
    localparam logic [APB_AW-1:0] BUDGET_ADDR = {REG_BUDGET, 2'b00};
    localparam logic [APB_AW-1:0] SPARE_ADDR  = 3'd4;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [TAG_W-1:0]  key;
        logic [SIZE_W-1:0] size;
    } t_req;

    typedef struct {
        logic               hit;
        logic               ev;
        logic [TAG_W-1:0]   ekey;
        logic [SIZE_W-1:0]  esize;
        logic [TOTAL_W-1:0] total;
        logic               last;
    } t_rsp;

    // clock, reset and dut inputs
    logic                i_clk;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    logic [IN_W-1:0]     in_data   = '0;
    logic                out_ready = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [APB_AW-1:0]   paddr     = '0;
    logic [APB_DW-1:0]   pwdata    = '0;

    // dut outputs
    logic                o_s_axis_tready;
    logic                o_m_axis_tvalid;
    logic [OUT_W-1:0]    o_m_axis_tdata;
    logic                o_m_axis_tlast;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // directory mirror
    logic [TAG_W-1:0]    dir_key   [N_SLOTS];
    logic [SIZE_W-1:0]   dir_size  [N_SLOTS];
    bit                  dir_valid [N_SLOTS];
    logic [SLOT_W-1:0]   dir_order [N_SLOTS];
    logic [TOTAL_W-1:0]  dir_total;
    int                  dir_live;
    logic [BUDGET_W-1:0] dir_budget;

    // request and result bookkeeping
    t_req                queued_reqs[$];
    t_rsp                due_results[$];
    t_req                in_item;
    int                  in_gap   = 0;
    int                  out_wait = 0;
    bit                  steady   = 1'b0;
    int unsigned         errors   = 0;
    int                  stall_cycles = 0;
    logic [TAG_W-1:0]    key_pool[KEY_POOL];

    byte_budget_lru_cache_directory_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (in_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // recency place of a live tag, -1 when absent
    function automatic int find_place(input logic [TAG_W-1:0] key);
        logic [SLOT_W-1:0] s;
        for (int i = 0; i < dir_live; i++) begin
            s = dir_order[i];
            if (dir_valid[s] && dir_key[s] == key)
                return i;
        end
        return -1;
    endfunction

    function automatic void move_front(input int pos);
        logic [SLOT_W-1:0] v;
        v = dir_order[pos];
        for (int i = pos; i > 0; i--)
            dir_order[i] = dir_order[i-1];
        dir_order[0] = v;
    endfunction

    // removes the entry at a recency place and hands back its slot
    function automatic logic [SLOT_W-1:0] drop_place(input int pos);
        logic [SLOT_W-1:0] v;
        v = dir_order[pos];
        for (int i = pos; i + 1 < dir_live; i++)
            dir_order[i] = dir_order[i+1];
        dir_order[dir_live-1] = v;
        dir_live--;
        dir_valid[v] = 1'b0;
        dir_total = dir_total - TOTAL_W'(dir_size[v]);
        return v;
    endfunction

    function automatic void add_result(input logic hit, input logic ev,
                                       input logic [TAG_W-1:0] ekey,
                                       input logic [SIZE_W-1:0] esize, input logic last);
        t_rsp r;
        r.hit   = hit;
        r.ev    = ev;
        r.ekey  = ekey;
        r.esize = esize;
        r.total = dir_total;
        r.last  = last;
        due_results = {due_results, r};
    endfunction

    // works out every result one accepted request causes
    function automatic void apply_request(input t_req rq);
        int                p;
        logic [SLOT_W-1:0] s;
        case (rq.func)
            FUNC_LOOKUP: begin
                p = find_place(rq.key);
                if (p >= 0)
                    move_front(p);
                add_result(p >= 0, 1'b0, '0, '0, 1'b1);
            end
            FUNC_INSERT: begin
                p = find_place(rq.key);
                // same tag goes away without a report
                if (p >= 0)
                    s = drop_place(p);
                // full table gives up its least-recent entry
                if (dir_live >= N_SLOTS) begin
                    s = drop_place(dir_live - 1);
                    add_result(1'b0, 1'b1, dir_key[s], dir_size[s], 1'b0);
                end
                s = dir_order[dir_live];
                dir_key[s]   = rq.key;
                dir_size[s]  = rq.size;
                dir_valid[s] = 1'b1;
                dir_total    = dir_total + TOTAL_W'(rq.size);
                dir_live++;
                move_front(dir_live - 1);
                add_result(1'b0, 1'b0, '0, '0, 1'b1);
            end
            FUNC_TRIM: begin
                if (dir_budget != '0) begin
                    while (dir_total > TOTAL_W'(dir_budget) && dir_live > 0) begin
                        s = drop_place(dir_live - 1);
                        add_result(1'b0, 1'b1, dir_key[s], dir_size[s], 1'b0);
                    end
                end
                add_result(1'b0, 1'b0, '0, '0, 1'b1);
            end
            default: add_result(1'b0, 1'b0, '0, '0, 1'b1);
        endcase
    endfunction

    task automatic check_field(input string name, input logic [TOTAL_W-1:0] want,
                               input logic [TOTAL_W-1:0] seen);
        if (seen !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, seen);
            errors++;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (in_valid && o_s_axis_tready)
                apply_request(in_item);
            if (!in_valid || o_s_axis_tready) begin
                if (in_gap > 0) begin
                    in_gap = in_gap - 1;
                    in_valid <= 1'b0;
                end else if (queued_reqs.size() > 0) begin
                    in_item = queued_reqs.pop_front();
                    in_data <= {{(IN_W-FUNC_W-TAG_W-SIZE_W){1'b0}},
                                in_item.size, in_item.key, in_item.func};
                    in_valid <= 1'b1;
                    in_gap = steady ? 0 : $urandom_range(0, 5);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            out_wait = 0;
        end else begin
            if (o_m_axis_tvalid && out_ready) begin
                if (due_results.size() == 0) begin
                    $error("result transfer with nothing due: tdata %0h, tlast %0b",
                           o_m_axis_tdata, o_m_axis_tlast);
                    errors++;
                end else begin
                    t_rsp want;
                    want = due_results.pop_front();
                    check_field("hit", want.hit, o_m_axis_tdata[0]);
                    check_field("evicted_valid", want.ev, o_m_axis_tdata[1]);
                    check_field("evicted_key", want.ekey, o_m_axis_tdata[33:2]);
                    check_field("evicted_size", want.esize, o_m_axis_tdata[65:34]);
                    check_field("total_bytes", want.total, o_m_axis_tdata[101:66]);
                    check_field("last", want.last, o_m_axis_tlast);
                end
                out_wait = steady ? 0 : $urandom_range(0, 5);
            end else if (out_wait > 0) begin
                out_wait = out_wait - 1;
            end
            out_ready <= (out_wait == 0);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_s_axis_tready) || (o_m_axis_tvalid && out_ready) ||
            (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // one register transfer; a read is checked against the mirror
    task automatic apb_xfer(input bit wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (!wr && prdata !== dir_budget) begin
            $error("budget_bytes readback mismatch: expected %0h, actual %0h",
                   dir_budget, prdata);
            errors++;
        end
        if (wr && addr == BUDGET_ADDR)
            dir_budget = data;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_budget(input logic [BUDGET_W-1:0] value);
        apb_xfer(1'b1, BUDGET_ADDR, value);
        apb_xfer(1'b0, BUDGET_ADDR, '0);
    endtask

    task automatic add_req(input logic [FUNC_W-1:0] func, input logic [TAG_W-1:0] key,
                           input logic [SIZE_W-1:0] size);
        t_req rq;
        rq.func = func;
        rq.key  = key;
        rq.size = size;
        queued_reqs = {queued_reqs, rq};
    endtask

    // wait until every request is in and every result is out
    task automatic wait_idle();
        do @(negedge i_clk);
        while (queued_reqs.size() != 0 || in_valid || due_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [TAG_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 80)
            return key_pool[$urandom_range(0, KEY_POOL - 1)];
        return $urandom;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(0, 4095);
        if (r < 80)
            return $urandom;
        if (r < 90)
            return $urandom_range(0, 1) ? '1 : '0;
        return $urandom_range(0, 32'h00FF_FFFF);
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return FUNC_LOOKUP;
        if (r < 75)
            return FUNC_INSERT;
        if (r < 92)
            return FUNC_TRIM;
        return FUNC_UNUSED;
    endfunction

    // stimulus
    initial begin
        logic [BUDGET_W-1:0] phase_budget[6];

        // mirror reset
        for (int i = 0; i < N_SLOTS; i++) begin
            dir_key[i]   = '0;
            dir_size[i]  = '0;
            dir_valid[i] = 1'b0;
            dir_order[i] = SLOT_W'(i);
        end
        dir_total  = '0;
        dir_live   = 0;
        dir_budget = '0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++)
            key_pool[i] = $urandom;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset value, then a write past the register list that must be ignored
        apb_xfer(1'b0, BUDGET_ADDR, '0);
        apb_xfer(1'b1, SPARE_ADDR, 32'hDEAD_BEEF);
        apb_xfer(1'b0, BUDGET_ADDR, '0);

        // directed: empty table, zero budget trim, extremes, replace, unused code
        add_req(FUNC_LOOKUP, '0, '0);
        add_req(FUNC_TRIM, '1, '1);
        add_req(FUNC_INSERT, '0, '0);
        add_req(FUNC_INSERT, '1, '1);
        add_req(FUNC_LOOKUP, '1, '0);
        add_req(FUNC_LOOKUP, '0, '1);
        add_req(FUNC_LOOKUP, 32'h5A5A_5A5A, '0);
        add_req(FUNC_INSERT, '0, 32'd100);
        add_req(FUNC_UNUSED, '1, '1);
        // fill the table and overflow it by count
        for (int i = 0; i < 16; i++)
            add_req(FUNC_INSERT, 32'h100 + i, 32'(i * 37));
        wait_idle();

        // smallest nonzero budget, trim that empties the table
        set_budget(32'd1);
        add_req(FUNC_TRIM, '0, '0);
        add_req(FUNC_TRIM, '0, '0);
        add_req(FUNC_INSERT, 32'd7, '1);
        add_req(FUNC_TRIM, '1, '0);
        add_req(FUNC_LOOKUP, 32'd7, '0);
        wait_idle();

        // random phases over several budgets
        phase_budget[0] = '1;
        phase_budget[1] = $urandom_range(2000, 20000);
        phase_budget[2] = '0;
        phase_budget[3] = $urandom;
        phase_budget[4] = 32'd1;
        phase_budget[5] = $urandom_range(100, 5000);
        for (int ph = 0; ph < 6; ph++) begin
            set_budget(phase_budget[ph]);
            steady = (ph == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                add_req(pick_func(), pick_key(), pick_size());
            wait_idle();
        end

        // quiet tail so a stray result would still be seen
        repeat (20) @(posedge i_clk);
        if (errors == 0 && due_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> byte_budget_lru_cache_directory_unit.f
hdl/bbl_pkg.sv
hdl/bbl_cell.sv
hdl/byte_budget_lru_cache_directory_unit.sv
test/tb_top.sv
